[rtl/rssr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssr_pkg
// Shared types and constants of the generator slot remapper.
// ----------------------------------------------------------------------------
package rssr_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int NCELL         = 4;
    localparam int CELLW         = 2;
    localparam int FP_W          = 64;
    localparam int CNT_W         = 11;
    localparam int IDX_W         = 10;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MAP   = 2'd2
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_COUNT = 2'd2;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic fp_we;
        logic used_we;
        logic used_wdata;
        logic wr_all;
        logic scan_rd;
        logic scan_clr;
    } t_cell_ctl;

endpackage

[rtl/rssr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rssr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rssr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssr_cell
// One bank of the fingerprint table and used marks. Scans its bank from the
// top down, keeps its first hit and passes the best hit up the chain.
// ----------------------------------------------------------------------------
module rssr_cell import rssr_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int CELL_ID   = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [((((MAX_ITEMS + NCELL - 1) / NCELL) > 1) ?
                   $clog2((MAX_ITEMS + NCELL - 1) / NCELL) : 1)-1:0] i_rd_addr,
    input  logic [((((MAX_ITEMS + NCELL - 1) / NCELL) > 1) ?
                   $clog2((MAX_ITEMS + NCELL - 1) / NCELL) : 1)-1:0] i_wr_addr,
    input  logic [CELLW-1:0]         i_wr_cell,
    input  logic [FP_W-1:0]          i_key,
    input  logic [$clog2(MAX_ITEMS + 1)-1:0] i_lim,
    input  logic                     i_chain_found,
    input  logic [CELLW-1:0]         i_chain_cell,
    input  logic [((((MAX_ITEMS + NCELL - 1) / NCELL) > 1) ?
                   $clog2((MAX_ITEMS + NCELL - 1) / NCELL) : 1)-1:0] i_chain_addr,
    output logic                     o_chain_found,
    output logic [CELLW-1:0]         o_chain_cell,
    output logic [((((MAX_ITEMS + NCELL - 1) / NCELL) > 1) ?
                   $clog2((MAX_ITEMS + NCELL - 1) / NCELL) : 1)-1:0] o_chain_addr,
    output logic                     o_used_rd
);

    localparam int BANK_D = (MAX_ITEMS + NCELL - 1) / NCELL;
    localparam int AW     = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int CW     = $clog2(MAX_ITEMS + 1);
    localparam int GW     = CW + 1;
    localparam logic [GW-1:0]    BASE = GW'(CELL_ID * BANK_D);
    localparam logic [CELLW-1:0] MY_CELL = CELLW'(CELL_ID);

    logic [FP_W-1:0] w_fp_q;
    logic [0:0]      w_used_q;
    logic            w_fp_we;
    logic            w_used_we;
    logic            w_hit;
    logic [GW-1:0]   w_gslot;

    logic            r_vld_d;
    logic [AW-1:0]   r_addr_d;
    logic            r_found;
    logic [AW-1:0]   r_hit_addr;
    logic            r_chain_found;
    logic [CELLW-1:0] r_chain_cell;
    logic [AW-1:0]   r_chain_addr;

    assign w_fp_we   = i_ctl.fp_we && (i_wr_cell == MY_CELL);
    assign w_used_we = i_ctl.used_we && (i_ctl.wr_all || (i_wr_cell == MY_CELL));

    rssr_ram #(.WIDTH(FP_W), .DEPTH(BANK_D)) u_fp_ram (
        .i_clk   (i_clk),
        .i_we    (w_fp_we),
        .i_waddr (i_wr_addr),
        .i_wdata (i_key),
        .i_raddr (i_rd_addr),
        .o_rdata (w_fp_q)
    );

    rssr_ram #(.WIDTH(1), .DEPTH(BANK_D)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (i_wr_addr),
        .i_wdata (i_ctl.used_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (w_used_q)
    );

    assign w_gslot = BASE + GW'(r_addr_d);
    assign w_hit   = r_vld_d && !w_used_q[0] && (w_fp_q == i_key) && (w_gslot < GW'(i_lim));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d       <= 1'b0;
            r_found       <= 1'b0;
            r_chain_found <= 1'b0;
        end else begin
            r_vld_d  <= i_ctl.scan_rd;
            r_addr_d <= i_rd_addr;
            if (i_ctl.scan_clr) begin
                r_found <= 1'b0;
            end else if (w_hit && !r_found) begin
                r_found    <= 1'b1;
                r_hit_addr <= r_addr_d;
            end
            // higher bank wins over anything from below
            if (r_found) begin
                r_chain_found <= 1'b1;
                r_chain_cell  <= MY_CELL;
                r_chain_addr  <= r_hit_addr;
            end else begin
                r_chain_found <= i_chain_found;
                r_chain_cell  <= i_chain_cell;
                r_chain_addr  <= i_chain_addr;
            end
        end
    end

    assign o_chain_found = r_chain_found;
    assign o_chain_cell  = r_chain_cell;
    assign o_chain_addr  = r_chain_addr;
    assign o_used_rd     = w_used_q[0];

endmodule

[rtl/rng_slot_remap_by_fingerprint.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rng_slot_remap_by_fingerprint
// Remaps generator slots of new items to old slots by fingerprint.
// ----------------------------------------------------------------------------
// The table is split over a chain of NCELL cells, each owning a bank of
// ceil(MAX_ITEMS/NCELL) fingerprints and used marks in its own RAMs. A map
// request that needs a search scans all banks in parallel from the top entry
// down, one RAM read per cycle, then lets the best hit ripple through the cell
// chain. Map requests with equal counts, no old slots or an empty table skip
// the search. Reset and every clear request start a pass that zeroes the used
// marks, during which no request is accepted. Configuration writes are always
// accepted.
// ----------------------------------------------------------------------------
module rng_slot_remap_by_fingerprint import rssr_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_operation,
    input  logic [FP_W-1:0]      i_fingerprint,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [IDX_W-1:0]     o_item_index,
    output logic                 o_reused,
    output logic [IDX_W-1:0]     o_old_slot,
    output logic [63:0]          o_fresh_seed,
    output logic                 o_last
);

    localparam int BANK_D = (MAX_ITEMS + NCELL - 1) / NCELL;
    localparam int AW     = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int CW     = $clog2(MAX_ITEMS + 1);
    localparam int XW     = (CW > CNT_W) ? CW : CNT_W;
    localparam int DW     = $clog2(NCELL + 2);
    localparam logic [XW-1:0] MAX_X  = XW'(MAX_ITEMS);
    localparam logic [AW-1:0] A_LAST = AW'(BANK_D - 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FALLRD,
        S_FALLCHK,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [63:0]      r_base_seed;
    logic [CNT_W-1:0] r_old_cnt;
    logic [CNT_W-1:0] r_new_cnt;
    logic [CW-1:0]    r_loaded;
    logic [CELLW-1:0] r_lc;
    logic [AW-1:0]    r_la;
    logic [CW-1:0]    r_i;
    logic [CELLW-1:0] r_ic;
    logic [AW-1:0]    r_ia;
    logic [AW-1:0]    r_sweep_a;
    logic [AW-1:0]    r_scan_a;
    logic [DW-1:0]    r_drain;
    logic [CW-1:0]    r_lim;
    logic [FP_W-1:0]  r_key;
    logic             r_reused;
    logic             r_mark;
    logic [CELLW-1:0] r_sel_c;
    logic [AW-1:0]    r_sel_a;

    logic             r_out_vld;
    logic [IDX_W-1:0] r_out_index;
    logic             r_out_reused;
    logic [IDX_W-1:0] r_out_slot;
    logic [63:0]      r_out_seed;
    logic             r_out_last;

    logic             w_in_take;
    logic             w_out_take;
    logic             w_out_free;
    logic             w_full;
    logic [XW-1:0]    w_o_x;
    logic [XW-1:0]    w_n_x;
    logic [CW-1:0]    w_o_eff;
    logic [CW-1:0]    w_n_eff;
    logic [CW-1:0]    w_lim;
    logic [31:0]      w_slot32;
    logic [31:0]      w_ch_slot32;
    logic [31:0]      w_i32;
    logic             w_used_sel;

    t_cell_ctl        w_ctl;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_wr_addr;
    logic [CELLW-1:0] w_wr_cell;
    logic [FP_W-1:0]  w_key;

    logic             w_ch_found [NCELL+1];
    logic [CELLW-1:0] w_ch_cell  [NCELL+1];
    logic [AW-1:0]    w_ch_addr  [NCELL+1];
    logic             w_used_rd  [NCELL];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_out_take  = r_out_vld && !i_out_stall;
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_full      = (r_loaded == CW'(MAX_ITEMS));

    assign w_o_x   = XW'(r_old_cnt);
    assign w_n_x   = XW'(r_new_cnt);
    assign w_o_eff = CW'((w_o_x > MAX_X) ? MAX_X : w_o_x);
    assign w_n_eff = CW'((w_n_x > MAX_X) ? MAX_X : w_n_x);
    assign w_lim   = (r_loaded < w_o_eff) ? r_loaded : w_o_eff;

    assign w_slot32    = 32'(r_sel_c) * 32'(BANK_D) + 32'(r_sel_a);
    assign w_ch_slot32 = 32'(w_ch_cell[NCELL]) * 32'(BANK_D) + 32'(w_ch_addr[NCELL]);
    assign w_i32       = 32'(r_i);
    assign w_used_sel  = w_used_rd[r_ic];

    // cell control
    always_comb begin
        w_ctl     = '0;
        w_rd_addr = r_scan_a;
        w_wr_addr = r_la;
        w_wr_cell = r_lc;
        w_key     = r_key;
        unique case (r_state)
            S_SWEEP: begin
                w_ctl.used_we = 1'b1;
                w_ctl.wr_all  = 1'b1;
                w_wr_addr     = r_sweep_a;
            end
            S_IDLE: begin
                w_key = i_fingerprint;
                if (w_in_take && (t_op'(i_operation) == OP_LOAD) && !w_full) begin
                    w_ctl.fp_we = 1'b1;
                end
                if (w_in_take && (t_op'(i_operation) == OP_MAP)) begin
                    w_ctl.scan_clr = 1'b1;
                end
            end
            S_SCAN: begin
                w_ctl.scan_rd = 1'b1;
            end
            S_FALLRD: begin
                w_rd_addr = r_ia;
            end
            S_DONE: begin
                w_wr_addr = r_sel_a;
                w_wr_cell = r_sel_c;
                if (w_out_free && r_mark) begin
                    w_ctl.used_we    = 1'b1;
                    w_ctl.used_wdata = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_ch_found[0] = 1'b0;
    assign w_ch_cell[0]  = '0;
    assign w_ch_addr[0]  = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rssr_cell #(.MAX_ITEMS(MAX_ITEMS), .CELL_ID(k)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_rd_addr     (w_rd_addr),
            .i_wr_addr     (w_wr_addr),
            .i_wr_cell     (w_wr_cell),
            .i_key         (w_key),
            .i_lim         (r_lim),
            .i_chain_found (w_ch_found[k]),
            .i_chain_cell  (w_ch_cell[k]),
            .i_chain_addr  (w_ch_addr[k]),
            .o_chain_found (w_ch_found[k+1]),
            .o_chain_cell  (w_ch_cell[k+1]),
            .o_chain_addr  (w_ch_addr[k+1]),
            .o_used_rd     (w_used_rd[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_seed <= '0;
            r_old_cnt   <= '0;
            r_new_cnt   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_BASE_SEED: r_base_seed <= i_cfg_data;
                REG_OLD_COUNT: r_old_cnt   <= i_cfg_data[CNT_W-1:0];
                REG_NEW_COUNT: r_new_cnt   <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_sweep_a <= '0;
            r_loaded  <= '0;
            r_lc      <= '0;
            r_la      <= '0;
            r_i       <= '0;
            r_ic      <= '0;
            r_ia      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (w_out_take) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    if (r_sweep_a == A_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_sweep_a <= r_sweep_a + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_in_take) begin
                        unique case (t_op'(i_operation))
                            OP_CLEAR: begin
                                r_loaded  <= '0;
                                r_lc      <= '0;
                                r_la      <= '0;
                                r_i       <= '0;
                                r_ic      <= '0;
                                r_ia      <= '0;
                                r_sweep_a <= '0;
                                r_state   <= S_SWEEP;
                            end
                            OP_LOAD: begin
                                if (!w_full) begin
                                    r_loaded <= r_loaded + 1'b1;
                                    if (r_la == A_LAST) begin
                                        r_la <= '0;
                                        r_lc <= r_lc + 1'b1;
                                    end else begin
                                        r_la <= r_la + 1'b1;
                                    end
                                end
                            end
                            OP_MAP: begin
                                r_key <= i_fingerprint;
                                if (r_i < w_n_eff) begin
                                    if (r_old_cnt == r_new_cnt) begin
                                        r_reused <= 1'b1;
                                        r_mark   <= 1'b0;
                                        r_sel_c  <= r_ic;
                                        r_sel_a  <= r_ia;
                                        r_state  <= S_DONE;
                                    end else if ((r_old_cnt == '0) || (r_loaded == '0)) begin
                                        r_reused <= 1'b0;
                                        r_mark   <= 1'b0;
                                        r_state  <= S_DONE;
                                    end else begin
                                        r_lim    <= w_lim;
                                        r_scan_a <= A_LAST;
                                        r_state  <= S_SCAN;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_scan_a == '0) begin
                        r_drain <= DW'(NCELL + 1);
                        r_state <= S_DRAIN;
                    end else begin
                        r_scan_a <= r_scan_a - 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_drain == '0) begin
                        if (w_ch_found[NCELL]) begin
                            r_reused <= 1'b1;
                            r_mark   <= 1'b1;
                            r_sel_c  <= w_ch_cell[NCELL];
                            r_sel_a  <= w_ch_addr[NCELL];
                            r_state  <= S_DONE;
                        end else if (r_i < w_o_eff) begin
                            r_state <= S_FALLRD;
                        end else begin
                            r_reused <= 1'b0;
                            r_mark   <= 1'b0;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_drain <= r_drain - 1'b1;
                    end
                end
                S_FALLRD: begin
                    r_state <= S_FALLCHK;
                end
                S_FALLCHK: begin
                    r_reused <= !w_used_sel;
                    r_mark   <= !w_used_sel;
                    r_sel_c  <= r_ic;
                    r_sel_a  <= r_ia;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_index  <= w_i32[IDX_W-1:0];
                        r_out_reused <= r_reused;
                        r_out_slot   <= r_reused ? w_slot32[IDX_W-1:0] : '0;
                        r_out_seed   <= r_reused ? 64'd0 : (r_base_seed + 64'(r_i));
                        r_out_last   <= (({1'b0, r_i} + 1'b1) == {1'b0, w_n_eff});
                        r_i          <= r_i + 1'b1;
                        if (r_ia == A_LAST) begin
                            r_ia <= '0;
                            r_ic <= r_ic + 1'b1;
                        end else begin
                            r_ia <= r_ia + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_item_index = r_out_index;
    assign o_reused     = r_out_reused;
    assign o_old_slot   = r_out_slot;
    assign o_fresh_seed = r_out_seed;
    assign o_last       = r_out_last;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result raised outside of completion");

    a_reused_no_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reused) |-> (o_fresh_seed == 64'd0))
        else $error("reused slot carries a fresh seed");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DRAIN) && (r_drain == '0) && w_ch_found[NCELL])
        |-> (w_ch_slot32 < 32'(r_lim)))
        else $error("search hit beyond scan limit");

    a_item_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i < CW'(MAX_ITEMS))
        |-> ((32'(r_ic) * 32'(BANK_D) + 32'(r_ia)) == w_i32))
        else $error("item bank position out of step with item index");

endmodule

[verif/rng_slot_remap_by_fingerprint_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rng_slot_remap_by_fingerprint_tb
// Self-checking bench for the fingerprint based generator slot remapper.
// ----------------------------------------------------------------------------
// A behavioral copy of the slot matching rules tracks the fingerprint table,
// used marks and counters, and queues the expected slot assignment for every
// accepted map request within the new count. Directed tests hit equal
// counts, seed wrap, the matching priorities, oversized equal counts and
// one long receiver hold-off that backs up the input side; random phases mix
// clears, loads, maps and unknown opcodes, some under idle and stall bursts.
// ----------------------------------------------------------------------------
module rng_slot_remap_by_fingerprint_tb;
    import rssr_pkg::*;

    localparam int TABLE_DEPTH    = MAX_ITEMS_DEF;
    localparam int SETTLE_CYCLES  = 320;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_REQS    = 420;
    localparam logic [1:0]           OP_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    typedef struct {
        logic [IDX_W-1:0] item_index;
        logic             reused;
        logic [IDX_W-1:0] old_slot;
        logic [63:0]      fresh_seed;
        logic             last;
    } t_slot_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_operation;
    logic [FP_W-1:0]      i_fingerprint;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [IDX_W-1:0]     o_item_index;
    logic                 o_reused;
    logic [IDX_W-1:0]     o_old_slot;
    logic [63:0]          o_fresh_seed;
    logic                 o_last;

    rng_slot_remap_by_fingerprint dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_fingerprint (i_fingerprint),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_item_index  (o_item_index),
        .o_reused      (o_reused),
        .o_old_slot    (o_old_slot),
        .o_fresh_seed  (o_fresh_seed),
        .o_last        (o_last)
    );

    // shadow state of the remapper
    logic [63:0]  shadow_fp [TABLE_DEPTH];
    bit           shadow_used [TABLE_DEPTH];
    int           shadow_loaded;
    int           shadow_next;
    logic [63:0]  seed_base;
    logic [CNT_W-1:0] old_cnt;
    logic [CNT_W-1:0] new_cnt;

    t_slot_result pending_slot_results[$];

    int  mismatches;
    int  results_checked;
    int  n_reused;
    int  n_fresh;
    int  n_loads;
    int  n_clears;
    int  req_sent;
    bit  idle_on;
    int  rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int clamp_count(logic [CNT_W-1:0] v);
        return (int'(v) > TABLE_DEPTH) ? TABLE_DEPTH : int'(v);
    endfunction

    // matching rules for one accepted request
    function automatic void remap_slot(logic [1:0] op, logic [63:0] fp);
        int           n_eff;
        int           o_eff;
        int           lim;
        int           idx;
        int           slot;
        bit           hit;
        t_slot_result r;
        n_eff = clamp_count(new_cnt);
        o_eff = clamp_count(old_cnt);
        idx   = shadow_next;
        hit   = 1'b0;
        slot  = 0;
        case (op)
            OP_CLEAR: begin
                foreach (shadow_used[k]) shadow_used[k] = 1'b0;
                shadow_loaded = 0;
                shadow_next   = 0;
                n_clears++;
            end
            OP_LOAD: begin
                if (shadow_loaded < TABLE_DEPTH) begin
                    shadow_fp[shadow_loaded] = fp;
                    shadow_loaded++;
                end
                n_loads++;
            end
            OP_MAP: begin
                if (idx < n_eff) begin
                    if (old_cnt == new_cnt) begin
                        hit  = 1'b1;
                        slot = idx;
                    end else if (old_cnt != 0 && shadow_loaded != 0) begin
                        lim = (shadow_loaded < o_eff) ? shadow_loaded : o_eff;
                        for (int j = lim - 1; j >= 0; j--) begin
                            if (!shadow_used[j] && shadow_fp[j] == fp) begin
                                hit  = 1'b1;
                                slot = j;
                                break;
                            end
                        end
                        if (!hit && idx < o_eff && !shadow_used[idx]) begin
                            hit  = 1'b1;
                            slot = idx;
                        end
                        if (hit) shadow_used[slot] = 1'b1;
                    end
                    r.item_index = idx[IDX_W-1:0];
                    r.reused     = hit;
                    r.old_slot   = hit ? slot[IDX_W-1:0] : '0;
                    r.fresh_seed = hit ? 64'd0 : seed_base + 64'(idx);
                    r.last       = (idx + 1 == n_eff);
                    pending_slot_results = {pending_slot_results, r};
                    shadow_next = idx + 1;
                    if (hit) n_reused++;
                    else     n_fresh++;
                end
            end
            default: ;
        endcase
    endfunction

    // request and config monitor
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BASE_SEED: seed_base = i_cfg_data;
                REG_OLD_COUNT: old_cnt   = i_cfg_data[CNT_W-1:0];
                REG_NEW_COUNT: new_cnt   = i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
        if (i_rst_n && i_in_valid && !o_in_stall)
            remap_slot(i_operation, i_fingerprint);
    end

    function automatic bit field_ok(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_results
        t_slot_result exp_r;
        bit           ok;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_slot_results.size() == 0) begin
                $display("%0t: unexpected result for item %0d", $time, o_item_index);
                mismatches++;
            end else begin
                exp_r = pending_slot_results.pop_front();
                ok = field_ok("item_index", 64'(exp_r.item_index), 64'(o_item_index))
                   & field_ok("reused", 64'(exp_r.reused), 64'(o_reused))
                   & field_ok("old_slot", 64'(exp_r.old_slot), 64'(o_old_slot))
                   & field_ok("fresh_seed", exp_r.fresh_seed, o_fresh_seed)
                   & field_ok("last", 64'(exp_r.last), 64'(o_last));
                if (!ok) mismatches++;
                results_checked++;
            end
        end
    end

    // receiver: long hold-off on demand, random stall bursts while idling is on
    initial begin : result_sink
        int burst;
        i_out_stall = 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                burst = $urandom_range(1, 8) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_req(logic [1:0] op, logic [63:0] fp);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_fingerprint <= fp;
        do @(posedge i_clk); while (o_in_stall);
        if (op != OP_UNKNOWN) req_sent++;
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // drain results, then let the remapper settle
    task automatic wait_idle();
        while (pending_slot_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_counts(logic [63:0] base, int old_v, int new_v);
        wait_idle();
        write_reg(REG_BASE_SEED, base);
        write_reg(REG_OLD_COUNT, 64'(old_v));
        write_reg(REG_NEW_COUNT, 64'(new_v));
    endtask

    task automatic test_equal_counts();
        wait_idle();
        write_reg(REG_SPARE, rand64());
        set_counts(64'h0123_4567_89ab_cdef, 3, 3);
        send_req(OP_CLEAR, '1);
        send_req(OP_MAP, '1);
        send_req(OP_MAP, '0);
        send_req(OP_MAP, rand64());
        send_req(OP_MAP, rand64());
        end_burst();
    endtask

    task automatic test_fresh_seeds();
        set_counts('1, 0, 2);
        send_req(OP_CLEAR, rand64());
        send_req(OP_MAP, rand64());
        send_req(OP_MAP, rand64());
        end_burst();
        // old slots exist but nothing loaded
        set_counts(rand64(), 3, 2);
        send_req(OP_CLEAR, '0);
        send_req(OP_MAP, rand64());
        end_burst();
    endtask

    task automatic test_fingerprint_match();
        logic [63:0] fa;
        logic [63:0] fb;
        fa = rand64();
        fb = rand64();
        set_counts(rand64(), 4, 6);
        send_req(OP_CLEAR, rand64());
        send_req(OP_LOAD, fa);
        send_req(OP_LOAD, fb);
        send_req(OP_LOAD, fa);
        send_req(OP_LOAD, '1);
        send_req(OP_UNKNOWN, fa);
        send_req(OP_MAP, fa);         // highest matching slot
        send_req(OP_MAP, fa);         // next lower match
        send_req(OP_MAP, fb);
        send_req(OP_MAP, rand64());   // own index free
        send_req(OP_MAP, '1);         // match used, index beyond old count
        send_req(OP_MAP, '0);
        send_req(OP_MAP, fa);         // surplus, dropped
        end_burst();
    endtask

    task automatic test_oversized_counts();
        // oversized but equal raw counts
        set_counts(rand64(), 2047, 2047);
        send_req(OP_CLEAR, rand64());
        repeat (4) send_req(OP_MAP, rand64());
        end_burst();
    endtask

    task automatic test_backpressure();
        set_counts(rand64(), 40, 40);
        send_req(OP_CLEAR, rand64());
        rx_hold = 600;
        repeat (40) send_req(OP_MAP, rand64());
        end_burst();
    endtask

    task automatic run_random_phase();
        logic [63:0] pool [4];
        logic [63:0] fp;
        int          mode;
        int          old_v;
        int          new_v;
        int          o_eff;
        int          n_eff;
        int          n_ld;
        int          n_mp;
        foreach (pool[k]) pool[k] = rand64();
        mode  = $urandom_range(0, 9);
        old_v = $urandom_range(1, 12);
        new_v = $urandom_range(1, 12);
        case (mode)
            0: new_v = old_v;
            1: old_v = 0;
            2: old_v = $urandom_range(TABLE_DEPTH + 1, 2047);
            3: new_v = $urandom_range(TABLE_DEPTH + 1, 2047);
            default: if (new_v == old_v) new_v = old_v + 1;
        endcase
        o_eff = (old_v > TABLE_DEPTH) ? TABLE_DEPTH : old_v;
        n_eff = (new_v > TABLE_DEPTH) ? TABLE_DEPTH : new_v;
        set_counts(($urandom_range(0, 7) == 0) ? '1 : rand64(), old_v, new_v);
        if (!idle_on || $urandom_range(0, 3) != 0) begin
        end
        if ($urandom_range(0, 3) != 0) send_req(OP_CLEAR, rand64());
        n_ld = $urandom_range(0, ((o_eff > 12) ? 12 : o_eff) + 2);
        for (int k = 0; k < n_ld; k++) begin
            fp = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 3)] : rand64();
            if ($urandom_range(0, 15) == 0) send_req(OP_UNKNOWN, rand64());
            send_req(OP_LOAD, fp);
        end
        n_mp = ((n_eff > 12) ? 8 : n_eff) + $urandom_range(0, 2);
        for (int k = 0; k < n_mp; k++) begin
            if ($urandom_range(0, 7) == 0)
                send_req(OP_LOAD, pool[$urandom_range(0, 3)]);
            if ($urandom_range(0, 39) == 0) send_req(OP_CLEAR, rand64());
            if ($urandom_range(0, 14) == 0) send_req(OP_UNKNOWN, pool[0]);
            fp = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 3)] : rand64();
            send_req(OP_MAP, fp);
        end
        end_burst();
    endtask

    task automatic test_random_mix();
        int start;
        start = req_sent;
        while (req_sent - start < RANDOM_REQS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            run_random_phase();
        end
    endtask

    task automatic test_random_no_idle();
        int start;
        idle_on = 1'b0;
        start   = req_sent;
        while (req_sent - start < 80) run_random_phase();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_operation   = OP_CLEAR;
        i_fingerprint = '0;
        seed_base     = '0;
        old_cnt       = '0;
        new_cnt       = '0;
        shadow_loaded = 0;
        shadow_next   = 0;
        foreach (shadow_used[k]) shadow_used[k] = 1'b0;
        foreach (shadow_fp[k]) shadow_fp[k] = '0;
        mismatches      = 0;
        results_checked = 0;
        n_reused = 0;
        n_fresh  = 0;
        n_loads  = 0;
        n_clears = 0;
        req_sent = 0;
        rx_hold  = 0;
        idle_on  = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_equal_counts();
        test_fresh_seeds();
        test_fingerprint_match();
        test_oversized_counts();
        test_backpressure();
        test_random_mix();
        test_random_no_idle();

        end_burst();
        while (pending_slot_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d clears, %0d loads, %0d remap results",
                 req_sent, n_clears, n_loads, results_checked);
        $display("slot outcomes: %0d reused old slots, %0d fresh seeds", n_reused, n_fresh);
        if (mismatches == 0 && pending_slot_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/rssr_pkg.sv
rtl/rssr_ram.sv
rtl/rssr_cell.sv
rtl/rng_slot_remap_by_fingerprint.sv
verif/rng_slot_remap_by_fingerprint_tb.sv
